// ===== hdl/dred_pkg.sv =====
// ----------------------------------------------------------------------------
// dred_pkg
// Shared types, register indexes and the quadrature step table for the
// debounced rotary encoder decoder.
// ----------------------------------------------------------------------------
package dred_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_KNOB_TICKS   = 2'd0;
	localparam logic [1:0] REG_BUTTON_TICKS = 2'd1;
	localparam logic [1:0] REG_DETENT       = 2'd2;

	// configuration reset values
	localparam logic [23:0] KNOB_TICKS_RST   = 24'd27500;
	localparam logic [23:0] BUTTON_TICKS_RST = 24'd2750000;
	localparam logic [3:0]  DETENT_RST       = 4'd4;

	// detent limits
	localparam logic [3:0] DETENT_MIN = 4'd1;
	localparam logic [3:0] DETENT_MAX = 4'd8;

	// pending action codes
	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_KNOB   = 2'd1;
	localparam logic [1:0] ACT_BUTTON = 2'd2;
	localparam logic [1:0] ACT_AUX    = 2'd3;

	// result kinds
	localparam logic KIND_KNOB   = 1'b0;
	localparam logic KIND_BUTTON = 1'b1;

	// step codes
	localparam logic signed [1:0] STEP_ZERO = 2'sb00;
	localparam logic signed [1:0] STEP_POS  = 2'sb01;
	localparam logic signed [1:0] STEP_NEG  = 2'sb11;

	// pin positions in the sample
	localparam int PIN_A   = 0;
	localparam int PIN_B   = 1;
	localparam int PIN_BTN = 2;
	localparam int PIN_AUX = 3;

	// lockout expiry, from the controller to the knob decoder and output
	typedef struct packed {
		logic knob;
		logic button;
		logic pressed;
	} fire_t;

	// detent step report from the knob decoder
	typedef struct packed {
		logic valid;
		logic neg;
	} step_t;

	// quadrature step for {previous AB, current AB}
	function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
		logic signed [1:0] d;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: d = STEP_NEG;
			4'd2, 4'd4, 4'd11, 4'd13: d = STEP_POS;
			default: d = STEP_ZERO;
		endcase
		return d;
	endfunction

endpackage

// ===== hdl/dred_ctrl.sv =====
// ----------------------------------------------------------------------------
// dred_ctrl
// Pin change detection and one-shot lockout counter; flags the tick on which
// a pending knob or button lockout expires.
// ----------------------------------------------------------------------------
module dred_ctrl import dred_pkg::*; #(
	parameter int LOCKOUT_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [3:0]  pins,
	input  logic [23:0] knob_ticks,
	input  logic [23:0] button_ticks,
	output fire_t       fire
);

	localparam int EXT_W = 33;

	logic [3:0]               hist_q;
	logic                     hist_valid_q;
	logic [1:0]               pend_q;
	logic [LOCKOUT_WIDTH-1:0] cnt_q;

	logic [3:0]               changed;
	logic                     expire;
	logic [LOCKOUT_WIDTH-1:0] knob_load;
	logic [LOCKOUT_WIDTH-1:0] button_load;

	// debounce value to counter load: zero means one, saturate to counter width
	function automatic logic [LOCKOUT_WIDTH-1:0] lockout_load(input logic [23:0] ticks);
		logic [EXT_W-1:0] ext;
		logic [EXT_W-1:0] maxv;
		logic [LOCKOUT_WIDTH-1:0] v;
		ext  = EXT_W'(ticks);
		maxv = EXT_W'({LOCKOUT_WIDTH{1'b1}});
		if (ticks == 24'd0)
			v = LOCKOUT_WIDTH'(1);
		else if (ext > maxv)
			v = '1;
		else
			v = ext[LOCKOUT_WIDTH-1:0];
		return v;
	endfunction

	assign knob_load   = lockout_load(knob_ticks);
	assign button_load = lockout_load(button_ticks);

	// first sample after reset never counts as a change
	assign changed = hist_valid_q ? (pins ^ hist_q) : 4'd0;

	// the count reaches zero on this tick
	assign expire = (cnt_q <= LOCKOUT_WIDTH'(1));

	// expiry flags
	always_comb begin
		fire.knob    = en && (pend_q == ACT_KNOB) && expire;
		fire.button  = en && (pend_q == ACT_BUTTON) && expire;
		fire.pressed = ~pins[PIN_BTN];
	end

	// history and lockout state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q       <= '0;
			hist_valid_q <= 1'b0;
			pend_q       <= ACT_NONE;
			cnt_q        <= '0;
		end else if (en) begin
			hist_q       <= pins;
			hist_valid_q <= 1'b1;
			case (pend_q)
				ACT_NONE: begin
					if (changed[PIN_A] || changed[PIN_B]) begin
						pend_q <= ACT_KNOB;
						cnt_q  <= knob_load;
					end else if (changed[PIN_BTN]) begin
						pend_q <= ACT_BUTTON;
						cnt_q  <= button_load;
					end else if (changed[PIN_AUX]) begin
						pend_q <= ACT_AUX;
						cnt_q  <= button_load;
					end
				end
				default: begin
					if (cnt_q != '0)
						cnt_q <= cnt_q - LOCKOUT_WIDTH'(1);
					if (expire)
						pend_q <= ACT_NONE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/dred_knob.sv =====
// ----------------------------------------------------------------------------
// dred_knob
// Quadrature decode against the last AB state and detent accumulation.
// ----------------------------------------------------------------------------
module dred_knob import dred_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire_knob,
	input  logic [1:0] cur_ab,
	input  logic [3:0] detent,
	output step_t      step
);

	logic [1:0]        last_ab_q;
	logic              last_ab_valid_q;
	logic signed [4:0] accum_q;

	logic [1:0]        prev_ab;
	logic signed [1:0] d;
	logic              reversal;
	logic signed [4:0] acc_sum;
	logic [3:0]        lim4;
	logic signed [4:0] lim;
	logic              hit_pos;
	logic              hit_neg;

	// clamp the detent register to its legal range
	always_comb begin
		if (detent < DETENT_MIN)
			lim4 = DETENT_MIN;
		else if (detent > DETENT_MAX)
			lim4 = DETENT_MAX;
		else
			lim4 = detent;
	end
	assign lim = $signed({1'b0, lim4});

	// seed on first decode, then table lookup
	assign prev_ab = last_ab_valid_q ? last_ab_q : cur_ab;
	assign d       = quad_delta({prev_ab, cur_ab});

	// accumulate, restarting on a change of direction
	assign reversal = ((accum_q > 5'sd0) && (d < 2'sd0)) || ((accum_q < 5'sd0) && (d > 2'sd0));
	assign acc_sum  = (reversal ? 5'sd0 : accum_q) + $signed({{3{d[1]}}, d});
	assign hit_pos  = (acc_sum >= lim);
	assign hit_neg  = (acc_sum <= -lim);

	always_comb begin
		step.valid = fire_knob && (hit_pos || hit_neg);
		step.neg   = hit_neg;
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ab_q       <= '0;
			last_ab_valid_q <= 1'b0;
			accum_q         <= '0;
		end else if (fire_knob) begin
			last_ab_q       <= cur_ab;
			last_ab_valid_q <= 1'b1;
			accum_q         <= (hit_pos || hit_neg) ? 5'sd0 : acc_sum;
		end
	end

endmodule

// ===== hdl/debounced_rotary_encoder_decoder.sv =====
// ----------------------------------------------------------------------------
// debounced_rotary_encoder_decoder
// Debounced quadrature knob and push button decoder, one pin sample per word.
//
// channel   dir  fields (lowest bit up)
// s_axis    in   tdata: enc_a_level, enc_b_level, enc_button_level, aux_button_level
// m_axis    out  tdata: step[1:0], pressed; tuser: event_kind
// cfg       in   0 knob_debounce_ticks, 1 button_debounce_ticks, 2 detent_counts
//
// one sample word per clock while no result is held; each word passes the
// input register and the decode logic into the result register
// the lockout counter counts accepted sample words, not clocks
// a held result stalls the input register, and ready drops once that is full
// reset clears the valid flags and decoder state, not the data registers, and loads the register defaults
// ----------------------------------------------------------------------------
module debounced_rotary_encoder_decoder import dred_pkg::*; #(
	parameter int LOCKOUT_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // enc_a_level, enc_b_level, enc_button_level, aux_button_level
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // step[1:0], pressed
	output logic        m_axis_tuser,  // event_kind
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);

	logic [23:0] knob_ticks_q;
	logic [23:0] button_ticks_q;
	logic [3:0]  detent_q;

	logic        valid_s1;
	logic [3:0]  pins_s1;

	logic        advance;
	fire_t       fire;
	step_t       step;

	logic        res_valid;
	logic        res_kind;
	logic [1:0]  res_step;
	logic        res_pressed;

	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic        out_kind_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knob_ticks_q   <= KNOB_TICKS_RST;
			button_ticks_q <= BUTTON_TICKS_RST;
			detent_q       <= DETENT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_KNOB_TICKS:   knob_ticks_q   <= cfg_wdata;
				REG_BUTTON_TICKS: button_ticks_q <= cfg_wdata;
				REG_DETENT:       detent_q       <= cfg_wdata[3:0];
				default:          ;
			endcase
		end
	end

	// a word moves on when the result register is free or being emptied
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			pins_s1 <= s_axis_tdata[3:0];
	end

	// change detection and lockout
	dred_ctrl #(
		.LOCKOUT_WIDTH(LOCKOUT_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.pins         (pins_s1),
		.knob_ticks   (knob_ticks_q),
		.button_ticks (button_ticks_q),
		.fire         (fire)
	);

	// quadrature decode
	dred_knob u_knob (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire_knob (fire.knob),
		.cur_ab    ({pins_s1[PIN_A], pins_s1[PIN_B]}),
		.detent    (detent_q),
		.step      (step)
	);

	// result select
	always_comb begin
		res_valid   = step.valid || fire.button;
		res_kind    = fire.button ? KIND_BUTTON : KIND_KNOB;
		res_step    = fire.button ? STEP_ZERO : (step.neg ? STEP_NEG : STEP_POS);
		res_pressed = fire.button && fire.pressed;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data_q <= {5'd0, res_pressed, res_step};
			out_kind_q <= res_kind;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	// knob and button never expire on the same tick
	a_one_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire.knob && fire.button))
		else $error("knob and button lockout expired together");

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !advance)
		else $error("result register overwritten while stalled");

	// knob results always carry a nonzero step
	a_knob_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == KIND_KNOB)) |-> (m_axis_tdata[1:0] != STEP_ZERO))
		else $error("knob result without a step");

	// a stalled sample word stays in the input register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("sample word lost from input register");

endmodule

// ===== tb/debounced_rotary_encoder_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// debounced_rotary_encoder_decoder_tb
// Self-checking bench for the debounced knob and button decoder. A short table
// of pin samples covers the first sample, knob seeding, one detent step,
// reversal, an invalid jump, bounce inside a lockout, button reports, the aux
// button and knob priority. Random phases follow under several debounce and
// detent settings. Every accepted sample goes through a local decoder model
// and every result word is checked against it in order.
// ----------------------------------------------------------------------------
module debounced_rotary_encoder_decoder_tb;
	import dred_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 6;
	localparam int PHASE_WORDS    = 155;
	localparam int NUM_ROWS       = 27;
	localparam int NUM_PHASES     = 8;

	// one result word
	typedef struct packed {
		logic              kind;
		logic signed [1:0] step;
		logic              pressed;
	} report_t;

	localparam report_t NO_REPORT = '0;

	// how a table row is checked
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_FIXED} row_check_t;

	typedef struct packed {
		row_check_t mode;
		logic [3:0] pins;     // aux, button, b, a
		report_t    fixed;
	} pin_row_t;

	// one random phase: register values, which pins may move, idling style
	typedef struct packed {
		logic [23:0] knob;
		logic [23:0] button;
		logic [3:0]  detent;
		logic [3:0]  pin_mask;
		bit          steady;
		bit          squeeze;
	} phase_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [23:0] cfg_wdata;

	debounced_rotary_encoder_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	// decoder model state and registers
	logic [23:0] knob_ticks;
	logic [23:0] button_ticks;
	logic [3:0]  detent_cfg;
	logic [3:0]  pin_hist;
	bit          hist_ok;
	logic [1:0]  pend;
	logic [23:0] lock_cnt;
	logic [1:0]  last_ab;
	bit          last_ab_ok;
	int          turn_accum;

	report_t     expected_reports[$];
	logic [3:0]  pins_now;
	int          fail_count;
	int          idle_cycles;
	int          phase_words;
	bit          steady;
	bit          squeeze_req;
	bit          squeeze_done;

	// directed pin samples, knob lockout 1, button lockout 2, detent at reset
	pin_row_t rows [NUM_ROWS] = '{
		'{EXP_NONE,  4'b0100, NO_REPORT},                          // first sample
		'{EXP_NONE,  4'b0100, NO_REPORT},
		'{EXP_NONE,  4'b0101, NO_REPORT},                          // a rises
		'{EXP_NONE,  4'b0101, NO_REPORT},                          // seeds last ab
		'{EXP_MODEL, 4'b0111, NO_REPORT},
		'{EXP_MODEL, 4'b0111, NO_REPORT},
		'{EXP_MODEL, 4'b0110, NO_REPORT},
		'{EXP_MODEL, 4'b0110, NO_REPORT},
		'{EXP_MODEL, 4'b0100, NO_REPORT},
		'{EXP_MODEL, 4'b0100, NO_REPORT},
		'{EXP_MODEL, 4'b0101, NO_REPORT},
		'{EXP_FIXED, 4'b0101, '{KIND_KNOB, STEP_POS, 1'b0}},       // fourth count
		'{EXP_MODEL, 4'b0100, NO_REPORT},                          // turn back
		'{EXP_MODEL, 4'b0100, NO_REPORT},
		'{EXP_MODEL, 4'b0111, NO_REPORT},                          // both bits jump
		'{EXP_NONE,  4'b0111, NO_REPORT},
		'{EXP_MODEL, 4'b0011, NO_REPORT},                          // press
		'{EXP_MODEL, 4'b0111, NO_REPORT},                          // bounce
		'{EXP_FIXED, 4'b0011, '{KIND_BUTTON, STEP_ZERO, 1'b1}},
		'{EXP_MODEL, 4'b0111, NO_REPORT},                          // release
		'{EXP_MODEL, 4'b0111, NO_REPORT},
		'{EXP_FIXED, 4'b0111, '{KIND_BUTTON, STEP_ZERO, 1'b0}},
		'{EXP_MODEL, 4'b1111, NO_REPORT},                          // aux only
		'{EXP_MODEL, 4'b1111, NO_REPORT},
		'{EXP_NONE,  4'b1111, NO_REPORT},
		'{EXP_MODEL, 4'b0010, NO_REPORT},                          // knob wins
		'{EXP_MODEL, 4'b0010, NO_REPORT}                           // reversal
	};

	phase_t phases [NUM_PHASES] = '{
		'{24'd1,        24'd1,        4'd1,  4'b1111, 1'b0, 1'b1},
		'{24'd0,        24'd0,        4'd0,  4'b1111, 1'b0, 1'b0},
		'{24'd3,        24'd5,        4'd4,  4'b1111, 1'b1, 1'b0},
		'{24'd2,        24'd16777215, 4'd8,  4'b0011, 1'b0, 1'b0},
		'{24'd16777215, 24'd3,        4'd2,  4'b1100, 1'b0, 1'b0},
		'{24'd5,        24'd2,        4'd15, 4'b1111, 1'b0, 1'b0},
		'{24'd1,        24'd4,        4'd9,  4'b1111, 1'b1, 1'b0},
		'{24'd4,        24'd1,        4'd3,  4'b1111, 1'b0, 1'b0}
	};

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// a zero register still locks out one tick
	function automatic logic [23:0] lockout_ticks(input logic [23:0] ticks);
		return (ticks == 24'd0) ? 24'd1 : ticks;
	endfunction

	// position of {a, b} on the clockwise quadrature ring
	function automatic int ring_pos(input logic [1:0] ab);
		case (ab)
			2'b00:   return 0;
			2'b10:   return 1;
			2'b11:   return 2;
			default: return 3;
		endcase
	endfunction

	// {a, b} at a ring position
	function automatic logic [1:0] ring_ab(input int pos);
		case (pos & 3)
			0:       return 2'b00;
			1:       return 2'b10;
			2:       return 2'b11;
			default: return 2'b01;
		endcase
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one sample tick of the decoder; returns 1 when a result word is due
	function automatic bit decode_tick(input logic [3:0] pins, output report_t rep);
		logic [3:0] moved;
		logic [1:0] ab;
		int         turn;
		int         lim;
		bit         fired;
		fired = 1'b0;
		rep = NO_REPORT;
		moved = hist_ok ? (pins ^ pin_hist) : 4'b0000;
		if (pend == ACT_NONE) begin
			if (moved[PIN_A] || moved[PIN_B]) begin
				pend = ACT_KNOB;
				lock_cnt = lockout_ticks(knob_ticks);
			end else if (moved[PIN_BTN]) begin
				pend = ACT_BUTTON;
				lock_cnt = lockout_ticks(button_ticks);
			end else if (moved[PIN_AUX]) begin
				pend = ACT_AUX;
				lock_cnt = lockout_ticks(button_ticks);
			end
		end else begin
			if (lock_cnt != 24'd0)
				lock_cnt = lock_cnt - 24'd1;
			if (lock_cnt == 24'd0) begin
				if (pend == ACT_KNOB) begin
					ab = {pins[PIN_A], pins[PIN_B]};
					if (!last_ab_ok) begin
						last_ab = ab;
						last_ab_ok = 1'b1;
					end
					// one step along the ring is a count, two is a bad jump
					case ((ring_pos(ab) - ring_pos(last_ab)) & 3)
						1:       turn = 1;
						3:       turn = -1;
						default: turn = 0;
					endcase
					last_ab = ab;
					lim = (detent_cfg < DETENT_MIN) ? DETENT_MIN :
						(detent_cfg > DETENT_MAX) ? DETENT_MAX : detent_cfg;
					if (turn != 0) begin
						if ((turn_accum > 0 && turn < 0) || (turn_accum < 0 && turn > 0))
							turn_accum = 0;
						turn_accum += turn;
					end
					if (turn_accum >= lim) begin
						turn_accum = 0;
						rep = '{KIND_KNOB, STEP_POS, 1'b0};
						fired = 1'b1;
					end else if (turn_accum <= -lim) begin
						turn_accum = 0;
						rep = '{KIND_KNOB, STEP_NEG, 1'b0};
						fired = 1'b1;
					end
				end else if (pend == ACT_BUTTON) begin
					rep = '{KIND_BUTTON, STEP_ZERO, ~pins[PIN_BTN]};
					fired = 1'b1;
				end
				pend = ACT_NONE;
			end
		end
		pin_hist = pins;
		hist_ok = 1'b1;
		return fired;
	endfunction

	// offer one sample word, wait for the accept, record what it should cause
	task automatic send_word(input logic [3:0] pins, input row_check_t mode,
			input report_t fixed);
		int      gap;
		report_t rep;
		bit      fired;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, pins};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pins_now = pins;
		phase_words++;
		fired = decode_tick(pins, rep);
		case (mode)
			EXP_MODEL: if (fired) expected_reports.push_back(rep);
			EXP_FIXED: expected_reports.push_back(fixed);
			default: ;
		endcase
	endtask

	// hold a new level past its lockout, with optional bounce on the moved pins
	task automatic hold_level(input logic [3:0] target, input logic [3:0] bounce_mask,
			input int lock);
		int         len;
		bit         bouncy;
		logic [3:0] noise;
		len = lock + 1 + $urandom_range(0, 2);
		bouncy = ($urandom_range(0, 3) == 0);
		send_word(target, EXP_MODEL, NO_REPORT);
		for (int i = 1; i < len; i++) begin
			noise = bounce_mask & 4'($urandom);
			if (bouncy && i < lock && $urandom_range(0, 1))
				send_word(target ^ noise, EXP_MODEL, NO_REPORT);
			else
				send_word(target, EXP_MODEL, NO_REPORT);
		end
	endtask

	// stop offering and let every expected word drain
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, mirrored into the model
	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_KNOB_TICKS:   knob_ticks = val;
			REG_BUTTON_TICKS: button_ticks = val;
			REG_DETENT:       detent_cfg = val[3:0];
			default: ;
		endcase
	endtask

	// one random stretch of pin activity within the phase's pin mask
	task automatic random_segment(input logic [3:0] mask);
		int         r;
		int         dir;
		int         pos;
		int         steps;
		int         knob_lock;
		int         btn_lock;
		logic [1:0] ab;
		logic [3:0] target;
		r = $urandom_range(0, 99);
		knob_lock = lockout_ticks(knob_ticks);
		btn_lock = lockout_ticks(button_ticks);
		if (mask[PIN_A] && r < 50) begin
			// turn the knob a few counts, now and then backing up
			dir = $urandom_range(0, 1) ? 1 : -1;
			steps = $urandom_range(1, 10);
			pos = ring_pos({pins_now[PIN_A], pins_now[PIN_B]});
			for (int s = 0; s < steps; s++) begin
				if ($urandom_range(0, 7) == 0)
					dir = -dir;
				pos = (pos + dir) & 3;
				ab = ring_ab(pos);
				target = pins_now;
				target[PIN_A] = ab[1];
				target[PIN_B] = ab[0];
				if (mask[PIN_BTN] && $urandom_range(0, 9) == 0)
					target[PIN_BTN] = ~target[PIN_BTN];
				hold_level(target, 4'b0011, knob_lock);
			end
		end else if (mask[PIN_A] && r < 56) begin
			hold_level(pins_now ^ 4'b0011, 4'b0011, knob_lock);
		end else if (mask[PIN_BTN] && r < 72) begin
			hold_level(pins_now ^ 4'b0100, 4'b0100, btn_lock);
		end else if (mask[PIN_AUX] && r < 80) begin
			hold_level(pins_now ^ 4'b1000, 4'b1000, btn_lock);
		end else begin
			// unstructured pin noise
			steps = $urandom_range(1, 6);
			for (int s = 0; s < steps; s++)
				send_word(pins_now ^ (mask & 4'($urandom)), EXP_MODEL, NO_REPORT);
		end
	endtask

	// result receiver, with one long hold-off when a phase asks for it
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				m_axis_tready <= 1'b1;
			end
		end
	end

	// result checks and watchdog
	always @(posedge clk) begin
		report_t exp_rep;
		logic signed [1:0] got_step;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_step = $signed(m_axis_tdata[1:0]);
			if (expected_reports.size() == 0) begin
				$error("result word with nothing expected: kind %0d step %0d pressed %0d",
					m_axis_tuser, got_step, m_axis_tdata[2]);
				fail_count++;
			end else begin
				exp_rep = expected_reports.pop_front();
				if (m_axis_tuser !== exp_rep.kind) begin
					$error("event_kind: expected %0d, got %0d", exp_rep.kind, m_axis_tuser);
					fail_count++;
				end
				if (got_step !== exp_rep.step) begin
					$error("step: expected %0d, got %0d", exp_rep.step, got_step);
					fail_count++;
				end
				if (m_axis_tdata[2] !== exp_rep.pressed) begin
					$error("pressed: expected %0d, got %0d", exp_rep.pressed,
						m_axis_tdata[2]);
					fail_count++;
				end
			end
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_KNOB_TICKS;
		cfg_wdata = 24'd0;
		knob_ticks = KNOB_TICKS_RST;
		button_ticks = BUTTON_TICKS_RST;
		detent_cfg = DETENT_RST;
		pin_hist = 4'b0000;
		hist_ok = 1'b0;
		pend = ACT_NONE;
		lock_cnt = 24'd0;
		last_ab = 2'b00;
		last_ab_ok = 1'b0;
		turn_accum = 0;
		pins_now = 4'b0000;
		fail_count = 0;
		idle_cycles = 0;
		phase_words = 0;
		steady = 1'b0;
		squeeze_req = 1'b0;
		squeeze_done = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// short lockouts for the table, detent left at its reset value
		write_reg(REG_KNOB_TICKS, 24'd1);
		write_reg(REG_BUTTON_TICKS, 24'd2);
		for (int i = 0; i < NUM_ROWS; i++)
			send_word(rows[i].pins, rows[i].mode, rows[i].fixed);

		// random phases
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_reg(REG_KNOB_TICKS, phases[p].knob);
			write_reg(REG_BUTTON_TICKS, phases[p].button);
			write_reg(REG_DETENT, {20'd0, phases[p].detent});
			steady = phases[p].steady;
			if (phases[p].squeeze)
				squeeze_req = 1'b1;
			phase_words = 0;
			while (phase_words < PHASE_WORDS)
				random_segment(phases[p].pin_mask);
		end
		steady = 1'b0;
		settle();

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
